// ----- hdl/vnfbm_pkg.sv -----
`timescale 1ns / 1ps

package vnfbm_pkg;

  localparam int NumOct    = 4;
  localparam int NumCorner = 4;
  localparam int CellDiv   = 24;

  localparam logic [31:0] MulX     = 32'd374761393;
  localparam logic [31:0] MulZ     = 32'd668265263;
  localparam logic [31:0] MulS     = 32'd1274126177;
  localparam logic [31:0] SeedStep = 32'd101;
  localparam logic [31:0] SeedReset = 32'd42;

  // Reciprocal of 24 in Q16; exact floor for coordinates below 2048.
  localparam logic [11:0] RecipCell = 12'd2731;

  // Normalizing divisor 15 * (2^24 - 1) and floor(2^48 / divisor).
  localparam logic [43:0] NormDen   = 44'd251658225;
  localparam logic [20:0] RecipNorm = 21'd1118481;

  localparam int HeightBase  = 18;
  localparam int HeightMin   = 4;
  localparam int BeachLimit  = 22;
  localparam int GridHeight  = 64;
  localparam int HeightMax   = GridHeight - 2;

  // APB register index
  localparam logic RegWorldSeed = 1'b0;

  typedef logic [23:0][15:0] fade_tbl_t;

  // Smoothstep weight for every cell remainder, worked out at elaboration.
  function automatic fade_tbl_t build_fade_tbl();
    fade_tbl_t   tbl;
    logic [63:0] f;
    logic [63:0] ff;
    logic [63:0] t;
    logic [63:0] p;
    for (int r = 0; r < CellDiv; r++) begin
      f  = (64'(r) * 64'd65536) / CellDiv;
      ff = f * f;
      t  = 64'd196608 - 64'd2 * f;
      p  = (ff * t) >> 32;
      tbl[r] = p[15:0];
    end
    return tbl;
  endfunction

  localparam fade_tbl_t FadeTbl = build_fade_tbl();

endpackage

// ----- hdl/value_noise_fbm_heightmap_top.sv -----
`timescale 1ns / 1ps
// An accepted request passes through all eleven register stages to the output register.
// Throughput: one request per cycle; the whole pipeline holds when the output is stalled.
// Every one of the eleven register stages takes a new request each cycle while the output is not stalled.
// Reset (rst_ni low, asynchronous) clears all valid bits and sets world_seed to 42.
// Payload registers are not reset.
module value_noise_fbm_heightmap_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // x_coord [7:0], z_coord [15:8]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // noise_value [15:0], column_height [21:16],
                                        // beach [22], zero [23]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vnfbm_pkg::*;

  logic [31:0] seed_q;
  logic        adv;
  logic [10:1] vld_q;
  logic        out_vld_q;
  logic [15:0] noise_q;
  logic [5:0]  height_q;
  logic        beach_q;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegWorldSeed) ? seed_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SeedReset;
    end else if (psel && penable && pwrite && paddr[2] == RegWorldSeed) begin
      seed_q <= pwdata;
    end
  end

  // The whole pipeline advances together.
  assign adv             = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[9:1], s_axis_tvalid_i};
      out_vld_q <= vld_q[10];
    end
  end

  // Stage 1: lattice cell, remainder and seed product per octave
  logic [6:0]  cx_d [NumOct];
  logic [6:0]  cz_d [NumOct];
  logic [4:0]  rx_d [NumOct];
  logic [4:0]  rz_d [NumOct];
  logic [31:0] sp_d [NumOct];
  logic [6:0]  cx_q [NumOct];
  logic [6:0]  cz_q [NumOct];
  logic [4:0]  rx_q [NumOct];
  logic [4:0]  rz_q [NumOct];
  logic [31:0] sp1_q [NumOct];

  always_comb begin
    logic [10:0] sx;
    logic [10:0] sz;
    logic [22:0] px;
    logic [22:0] pz;
    logic [31:0] sd;
    for (int o = 0; o < NumOct; o++) begin
      sx = {3'b0, s_axis_tdata_i[7:0]} << o;
      sz = {3'b0, s_axis_tdata_i[15:8]} << o;
      px = 23'(sx) * 23'(RecipCell);
      pz = 23'(sz) * 23'(RecipCell);
      cx_d[o] = px[22:16];
      cz_d[o] = pz[22:16];
      rx_d[o] = 5'(sx - 11'(px[22:16]) * 11'(CellDiv));
      rz_d[o] = 5'(sz - 11'(pz[22:16]) * 11'(CellDiv));
      sd = seed_q + 32'(SeedStep * 32'(o));
      sp_d[o] = sd * MulS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cx_q  <= cx_d;
      cz_q  <= cz_d;
      rx_q  <= rx_d;
      rz_q  <= rz_d;
      sp1_q <= sp_d;
    end
  end

  // Stage 2: coordinate products and smoothstep weights
  logic [31:0] px_q [NumOct];
  logic [31:0] pz_q [NumOct];
  logic [31:0] sp2_q [NumOct];
  logic [15:0] ux2_q [NumOct];
  logic [15:0] uz2_q [NumOct];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int o = 0; o < NumOct; o++) begin
        px_q[o]  <= {25'd0, cx_q[o]} * MulX;
        pz_q[o]  <= {25'd0, cz_q[o]} * MulZ;
        ux2_q[o] <= FadeTbl[rx_q[o]];
        uz2_q[o] <= FadeTbl[rz_q[o]];
      end
      sp2_q <= sp1_q;
    end
  end

  // Stage 3: corner sums and first xor-shift; corners a, b, c, d
  logic [31:0] t_q [NumOct][NumCorner];
  logic [15:0] ux3_q [NumOct];
  logic [15:0] uz3_q [NumOct];

  always_ff @(posedge clk_i) begin
    logic [31:0] n;
    if (adv) begin
      for (int o = 0; o < NumOct; o++) begin
        for (int c = 0; c < NumCorner; c++) begin
          n = px_q[o] + pz_q[o] + sp2_q[o]
              + (c[0] ? MulX : 32'd0) + (c[1] ? MulZ : 32'd0);
          t_q[o][c] <= n ^ (n >> 13);
        end
      end
      ux3_q <= ux2_q;
      uz3_q <= uz2_q;
    end
  end

  // Stage 4: second hash multiply
  logic [31:0] m_q [NumOct][NumCorner];
  logic [15:0] ux4_q [NumOct];
  logic [15:0] uz4_q [NumOct];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int o = 0; o < NumOct; o++) begin
        for (int c = 0; c < NumCorner; c++) begin
          m_q[o][c] <= t_q[o][c] * MulS;
        end
      end
      ux4_q <= ux3_q;
      uz4_q <= uz3_q;
    end
  end

  // Stage 5: lattice values and blend along x
  logic signed [41:0] ab5_q [NumOct];
  logic signed [41:0] cd5_q [NumOct];
  logic [15:0]        uz5_q [NumOct];

  always_ff @(posedge clk_i) begin
    logic [23:0]        h [NumCorner];
    logic [31:0]        mm;
    logic signed [24:0] dab;
    logic signed [24:0] dcd;
    logic signed [41:0] wx;
    if (adv) begin
      for (int o = 0; o < NumOct; o++) begin
        for (int c = 0; c < NumCorner; c++) begin
          mm   = m_q[o][c] ^ (m_q[o][c] >> 16);
          h[c] = mm[23:0];
        end
        dab = $signed({1'b0, h[1]}) - $signed({1'b0, h[0]});
        dcd = $signed({1'b0, h[3]}) - $signed({1'b0, h[2]});
        wx  = 42'($signed({1'b0, ux4_q[o]}));
        ab5_q[o] <= $signed({2'b0, h[0], 16'd0}) + 42'(dab) * wx;
        cd5_q[o] <= $signed({2'b0, h[2], 16'd0}) + 42'(dcd) * wx;
      end
      uz5_q <= uz4_q;
    end
  end

  // Stage 6: difference for the blend along z
  logic signed [41:0] ab6_q [NumOct];
  logic signed [41:0] dif_q [NumOct];
  logic [15:0]        uz6_q [NumOct];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int o = 0; o < NumOct; o++) begin
        dif_q[o] <= cd5_q[o] - ab5_q[o];
      end
      ab6_q <= ab5_q;
      uz6_q <= uz5_q;
    end
  end

  // Stage 7: the wide product split into a low and a high partial product
  logic signed [41:0] ab7_q [NumOct];
  logic [39:0]        plo_q [NumOct];
  logic signed [34:0] phi_q [NumOct];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int o = 0; o < NumOct; o++) begin
        plo_q[o] <= 40'(dif_q[o][23:0]) * 40'(uz6_q[o]);
        phi_q[o] <= 35'($signed(dif_q[o][41:24])) * 35'($signed({1'b0, uz6_q[o]}));
      end
      ab7_q <= ab6_q;
    end
  end

  // Stage 8: octave value in units of 1/(2^24-1)
  logic [23:0] so_q [NumOct];

  always_ff @(posedge clk_i) begin
    logic signed [59:0] r;
    if (adv) begin
      for (int o = 0; o < NumOct; o++) begin
        r = (60'(ab7_q[o]) <<< 16) + $signed({20'd0, plo_q[o]})
            + (60'(phi_q[o]) <<< 24);
        so_q[o] <= r[59] ? 24'd0 : r[55:32];
      end
    end
  end

  // Stage 9: weighted octave sum
  logic [27:0] v9_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      v9_q <= {1'b0, so_q[0], 3'b0} + {2'b0, so_q[1], 2'b0}
              + {3'b0, so_q[2], 1'b0} + {4'b0, so_q[3]};
    end
  end

  // Stage 10: quotient estimate by reciprocal, at most one below the true value
  logic [27:0] v10_q;
  logic [16:0] qe_q;

  always_ff @(posedge clk_i) begin
    logic [48:0] prod;
    if (adv) begin
      prod  = 49'(v9_q) * 49'(RecipNorm);
      qe_q  <= prod[48:32];
      v10_q <= v9_q;
    end
  end

  // Stage 11: correction, saturation and height; the divisor is 15*2^24 - 15.
  always_ff @(posedge clk_i) begin
    logic [19:0] q15;
    logic [43:0] qden;
    logic [43:0] rem;
    logic [16:0] q;
    logic [8:0]  h;
    if (adv) begin
      q15  = 20'(qe_q) * 20'd15;
      qden = {q15, 24'd0} - 44'(q15);
      rem  = {v10_q, 16'd0} - qden;
      q    = (rem >= NormDen) ? qe_q + 17'd1 : qe_q;
      noise_q <= q[16] ? 16'hFFFF : q[15:0];
      h = 9'(HeightBase) + 9'(q[16:12]);
      if (h < 9'(HeightMin)) h = 9'(HeightMin);
      if (h >= 9'(HeightMax)) h = 9'(HeightMax);
      height_q <= h[5:0];
      beach_q  <= (h < 9'(BeachLimit));
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, beach_q, height_q, noise_q};

  // Assertions
  a_ready_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready does not follow the output stage");

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(vld_q))
    else $error("pipeline moved during an output stall");

  a_beach_matches_height: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (beach_q == (height_q < 6'(BeachLimit))))
    else $error("beach flag disagrees with the column height");

  a_height_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (height_q >= 6'(HeightBase) && height_q <= 6'(HeightMax)))
    else $error("column height out of range");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import vnfbm_pkg::*;

  typedef struct packed {
    logic [15:0] noise;
    logic [5:0]  height;
    logic        beach;
  } column_t;

  typedef struct {
    logic [7:0] x;
    logic [7:0] z;
  } coord_t;

  localparam int WatchLimit = 5000;
  localparam int RandPerSeed = 222;
  localparam logic [2:0] SeedAddr = {RegWorldSeed, 2'b00};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;   // x_coord [7:0], z_coord [15:8]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;        // noise [15:0], height [21:16], beach [22], zero [23]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [31:0] seed_shadow = SeedReset;
  column_t     pending_columns[$];
  int          mismatches = 0;
  int          stall_count = 0;
  int          cycle_count = 0;
  logic        calm;

  always #5 clk_i = ~clk_i;

  value_noise_fbm_heightmap_top uut (.*);

  // A long stretch of the run where neither side idles.
  assign calm = (cycle_count >= 600) && (cycle_count < 1400);

  function automatic logic [23:0] lattice_hash(logic [31:0] cx, logic [31:0] cz,
                                               logic [31:0] sd);
    logic [31:0] n;
    n = cx * MulX + cz * MulZ + sd * MulS;
    n = (n ^ (n >> 13)) * MulS;
    n = n ^ (n >> 16);
    return n[23:0];
  endfunction

  function automatic longint smooth_weight(logic [63:0] f);
    logic [63:0] sq;
    logic [63:0] t;
    sq = f * f;
    t  = 64'd196608 - 64'd2 * f;
    return longint'((sq * t) >> 32);
  endfunction

  function automatic longint octave_value(logic [7:0] x, logic [7:0] z, int o,
                                          logic [31:0] sd);
    logic [31:0] sx, sz, cx, cz;
    longint ux, uz, a, b, c, d, ab, cd, r;
    sx = 32'(x) << o;
    sz = 32'(z) << o;
    cx = sx / CellDiv;
    cz = sz / CellDiv;
    ux = smooth_weight(64'((sx % CellDiv) * 65536 / CellDiv));
    uz = smooth_weight(64'((sz % CellDiv) * 65536 / CellDiv));
    a  = longint'(lattice_hash(cx, cz, sd));
    b  = longint'(lattice_hash(cx + 1, cz, sd));
    c  = longint'(lattice_hash(cx, cz + 1, sd));
    d  = longint'(lattice_hash(cx + 1, cz + 1, sd));
    ab = a * 65536 + (b - a) * ux;
    cd = c * 65536 + (d - c) * ux;
    r  = ab * 65536 + (cd - ab) * uz;
    if (r < 0) begin
      r = 0;
    end
    return r >>> 32;
  endfunction

  function automatic column_t predict_column(logic [7:0] x, logic [7:0] z);
    column_t     res;
    longint      v;
    longint      den;
    longint      nz;
    longint      ht;
    logic [31:0] sd;
    v   = 0;
    den = 64'd15 * 64'hFFFFFF;
    for (int o = 0; o < NumOct; o++) begin
      sd = seed_shadow + SeedStep * o;
      v += octave_value(x, z, o, sd) << (3 - o);
    end
    nz = (v * 65536) / den;
    if (nz > 65535) begin
      nz = 65535;
    end
    ht = HeightBase + (v * 16) / den;
    if (ht < HeightMin) begin
      ht = HeightMin;
    end
    if (ht > HeightMax) begin
      ht = HeightMax;
    end
    res.noise  = nz[15:0];
    res.height = ht[5:0];
    res.beach  = (ht < BeachLimit);
    return res;
  endfunction

  task automatic send_column(logic [7:0] x, logic [7:0] z);
    while (!calm && $urandom_range(99) < 33) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {z, x};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_columns.push_back(predict_column(x, z));
  endtask

  task automatic write_seed(logic [31:0] value);
    wait (pending_columns.size() == 0);
    // Let the pipeline run empty before the seed changes under it.
    repeat (20) @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= SeedAddr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    seed_shadow = value;
  endtask

  always @(posedge clk_i) begin
    column_t want;
    column_t got;
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      m_axis_tready_i <= calm || ($urandom_range(99) >= 33);
    end
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got.noise  = m_axis_tdata_o[15:0];
      got.height = m_axis_tdata_o[21:16];
      got.beach  = m_axis_tdata_o[22];
      if (pending_columns.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected column result %h", m_axis_tdata_o);
        end
      end else begin
        want = pending_columns.pop_front();
        if (got.noise !== want.noise || got.height !== want.height ||
            got.beach !== want.beach || m_axis_tdata_o[23] !== 1'b0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("column mismatch: noise %0d/%0d height %0d/%0d beach %0d/%0d pad %b",
                     want.noise, got.noise, want.height, got.height,
                     want.beach, got.beach, m_axis_tdata_o[23]);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
    end
    if (stall_count >= WatchLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    coord_t      corners[$];
    logic [31:0] seeds[$];
    corners = '{
      '{8'd0, 8'd0}, '{8'd255, 8'd255}, '{8'd0, 8'd255}, '{8'd255, 8'd0},
      '{8'd1, 8'd1}, '{8'd23, 8'd23}, '{8'd24, 8'd24}, '{8'd12, 8'd12},
      '{8'd47, 8'd48}, '{8'd127, 8'd128}, '{8'd128, 8'd127}, '{8'd170, 8'd85},
      '{8'd85, 8'd170}, '{8'd240, 8'd239}, '{8'd3, 8'd250}, '{8'd96, 8'd0},
      '{8'd0, 8'd96}, '{8'd254, 8'd1}
    };
    seeds = '{32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, $urandom};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // First pass runs with the seed left by reset.
    foreach (corners[i]) begin
      send_column(corners[i].x, corners[i].z);
    end
    for (int p = 0; p <= seeds.size(); p++) begin
      if (p > 0) begin
        s_axis_tvalid_i <= 1'b0;
        write_seed(seeds[p - 1]);
        foreach (corners[i]) begin
          if (i < 4) begin
            send_column(corners[i].x, corners[i].z);
          end
        end
      end
      for (int n = 0; n < RandPerSeed; n++) begin
        send_column(8'($urandom), 8'($urandom));
      end
    end
    s_axis_tvalid_i <= 1'b0;
    wait (pending_columns.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/vnfbm_pkg.sv
hdl/value_noise_fbm_heightmap_top.sv
tb/testbench.sv
